[hw/rtl/i2c_master_transfer_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// I2C transfer sequencer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define I2CMTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define I2CMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/i2cmts_pkg.sv]
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Transaction types, command and phase codes, and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmts_pkg;

	// Command codes carried by an input transaction
	typedef enum logic [1:0] {
		CMD_EVENT    = 2'd0,
		CMD_WRITE    = 2'd1,
		CMD_READ     = 2'd2,
		CMD_RESERVED = 2'd3
	} i2cmts_cmd_t;

	// Transfer phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WRITE   = 2'd1,
		PH_RD_DATA = 2'd2,
		PH_RD_ADDR = 2'd3
	} i2cmts_phase_t;

	// Configuration register map
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic [0:0]  REG_MEM_DEV = 1'b0;
	localparam logic [0:0]  REG_RD_DEV  = 1'b1;

	localparam logic [7:0] MEM_DEV_ADDR_RST = 8'hA0;
	localparam logic [7:0] RD_DEV_ADDR_RST  = 8'hD0;
	localparam logic [7:0] ADDR_PAGE_BIT    = 8'h02;
	localparam logic [7:0] ADDR_READ_BIT    = 8'h01;

	// Input transaction
	typedef struct packed {
		logic [1:0]  cmd;
		logic [8:0]  register_address;
		logic [15:0] transfer_length;
		logic        start_sent;
		logic        address_sent;
		logic        byte_finished;
		logic        tx_empty;
		logic        rx_not_empty;
		logic        ack_failure;
		logic [7:0]  tx_byte;
		logic [7:0]  rx_byte;
	} i2cmts_in_t;

	// Result transaction
	typedef struct packed {
		logic        dr_write;
		logic [7:0]  dr_value;
		logic        gen_start;
		logic        gen_stop;
		logic        ack_enable;
		logic        buffer_irq_enable;
		logic        event_irq_enable;
		logic        error_irq_enable;
		logic        tx_byte_taken;
		logic        rx_byte_stored;
		logic [7:0]  rx_data;
		logic [15:0] bytes_left;
	} i2cmts_out_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [7:0] mem_dev_addr;
		logic [7:0] rd_dev_addr;
	} i2cmts_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/i2cmts_cfg.sv]
// ----------------------------------------------------------------------------
// I2C transfer sequencer configuration registers
// APB-style access to the memory and read device address bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_cfg import i2cmts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output i2cmts_cfg_t                cfg
);

	logic [7:0] mem_dev_q;
	logic [7:0] rd_dev_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Write the addressed register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_dev_q <= MEM_DEV_ADDR_RST;
			rd_dev_q  <= RD_DEV_ADDR_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MEM_DEV: mem_dev_q <= pwdata[7:0];
				REG_RD_DEV:  rd_dev_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (paddr[2])
			REG_MEM_DEV: prdata = {24'h000000, mem_dev_q};
			REG_RD_DEV:  prdata = {24'h000000, rd_dev_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg = '{mem_dev_addr: mem_dev_q, rd_dev_addr: rd_dev_q};

endmodule

`default_nettype wire

[hw/rtl/i2cmts_seq.sv]
// ----------------------------------------------------------------------------
// I2C transfer sequencer step logic
// Transfer state registers and the per-transaction decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_seq import i2cmts_pkg::*; #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step_en,
	input  wire i2cmts_in_t  evt,
	input  wire i2cmts_cfg_t cfg,
	output i2cmts_out_t      res
);

	i2cmts_phase_t         phase_q, phase_d;
	logic [7:0]            slave_q, slave_d;
	logic [7:0]            sub_q, sub_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic                  ack_q, ack_d;
	logic                  buf_q, buf_d;
	logic                  ev_q, ev_d;
	logic                  err_q, err_d;
	logic [COUNT_BITS+15:0] len_ext;
	logic [COUNT_BITS+15:0] left_ext;
	logic                  odd_phase;

	// Fit the byte count to the counter width
	assign len_ext   = {{COUNT_BITS{1'b0}}, evt.transfer_length};
	assign odd_phase = (phase_q == PH_WRITE) || (phase_q == PH_RD_ADDR);

	// Hold state on idle cycles, advance on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			slave_q <= '0;
			sub_q   <= '0;
			cnt_q   <= '0;
			ack_q   <= 1'b0;
			buf_q   <= 1'b0;
			ev_q    <= 1'b0;
			err_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			slave_q <= slave_d;
			sub_q   <= sub_d;
			cnt_q   <= cnt_d;
			ack_q   <= ack_d;
			buf_q   <= buf_d;
			ev_q    <= ev_d;
			err_q   <= err_d;
		end
	end

	// Next state and result for one transaction
	always_comb begin
		phase_d = phase_q;
		slave_d = slave_q;
		sub_d   = sub_q;
		cnt_d   = cnt_q;
		ack_d   = ack_q;
		buf_d   = buf_q;
		ev_d    = ev_q;
		err_d   = err_q;

		res.dr_write       = 1'b0;
		res.dr_value       = '0;
		res.gen_start      = 1'b0;
		res.gen_stop       = 1'b0;
		res.tx_byte_taken  = 1'b0;
		res.rx_byte_stored = 1'b0;
		res.rx_data        = '0;

		unique case (i2cmts_cmd_t'(evt.cmd))
			CMD_WRITE: begin
				slave_d = cfg.mem_dev_addr
					| (evt.register_address[8] ? ADDR_PAGE_BIT : 8'h00);
				phase_d = PH_WRITE;
				sub_d   = evt.register_address[7:0];
				cnt_d   = len_ext[COUNT_BITS-1:0];
				ev_d    = 1'b1;
				res.gen_start = 1'b1;
			end
			CMD_READ: begin
				slave_d = cfg.rd_dev_addr;
				phase_d = PH_RD_ADDR;
				sub_d   = evt.register_address[7:0];
				cnt_d   = len_ext[COUNT_BITS-1:0];
				ev_d    = 1'b1;
				res.gen_start = 1'b1;
			end
			CMD_EVENT: begin
				if (ev_q) begin
					// Start sent: send the slave address byte
					if (evt.start_sent) begin
						res.dr_write = 1'b1;
						if (odd_phase) begin
							res.dr_value = slave_q;
							err_d        = 1'b1;
						end else begin
							res.dr_value = slave_q | ADDR_READ_BIT;
						end
					end
					// Address sent: send sub-address or arm receive
					if (evt.address_sent) begin
						if (odd_phase) begin
							res.dr_write = 1'b1;
							res.dr_value = sub_q;
							if (phase_q == PH_WRITE)
								buf_d = (cnt_q != '0);
						end else begin
							ack_d = (cnt_q > COUNT_BITS'(1));
							buf_d = 1'b1;
						end
					end
					// Byte finished: repeated start for reads, else stop
					if (evt.byte_finished) begin
						if (phase_q == PH_RD_ADDR) begin
							res.gen_start = 1'b1;
							phase_d       = PH_RD_DATA;
						end else begin
							ev_d         = 1'b0;
							err_d        = 1'b0;
							res.gen_stop = 1'b1;
						end
					end
					// Buffer flags move data bytes and count down
					if (buf_d) begin
						if (evt.tx_empty) begin
							res.dr_write      = 1'b1;
							res.dr_value      = evt.tx_byte;
							res.tx_byte_taken = 1'b1;
							if (cnt_d != '0)
								cnt_d = cnt_d - COUNT_BITS'(1);
							if (cnt_d == '0)
								buf_d = 1'b0;
						end
						if (evt.rx_not_empty) begin
							res.rx_byte_stored = 1'b1;
							res.rx_data        = evt.rx_byte;
							if (cnt_d != '0)
								cnt_d = cnt_d - COUNT_BITS'(1);
							if (cnt_d == COUNT_BITS'(1)) begin
								ack_d        = 1'b0;
								res.gen_stop = 1'b1;
							end else if (cnt_d == '0) begin
								buf_d = 1'b0;
								ev_d  = 1'b0;
								err_d = 1'b0;
							end
						end
					end
				end
				// Ack failure: drop all interrupts and stop
				if (err_q && evt.ack_failure) begin
					ev_d         = 1'b0;
					err_d        = 1'b0;
					buf_d        = 1'b0;
					res.gen_stop = 1'b1;
				end
			end
			default: ;
		endcase

		res.ack_enable        = ack_d;
		res.buffer_irq_enable = buf_d;
		res.event_irq_enable  = ev_d;
		res.error_irq_enable  = err_d;

		// Report the low 16 bits of the count
		left_ext       = {16'h0000, cnt_d};
		res.bytes_left = left_ext[15:0];
	end

endmodule

`default_nettype wire

[hw/rtl/i2c_master_transfer_sequencer_core.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Drives register read and write transfers of an I2C master controller.
// ----------------------------------------------------------------------------
// Usage:
//   evt channel (evt_valid/evt_ready/evt) carries begin-write, begin-read and
//   status-event transactions. res channel (res_valid/res_ready/res) returns
//   one result transaction per input: data-register write, start/stop
//   requests, acknowledge and interrupt-enable settings, and buffer traffic.
//   The APB port holds the memory and read device address bytes; write them
//   only while no transaction is in flight.
// Pipeline and throughput:
//   A transaction lands in the input register at acceptance, is decided from
//   there and is written to the result register, which drives res, once the
//   result slot is free. One transaction is taken per cycle while res is not
//   stalled; the transfer state loop closes within the single decision stage.
// Reset:
//   arst_n clears the transfer state to idle with all enables low and loads
//   the address registers with their default values.
// Stall:
//   While res_valid is high and res_ready low, res holds; the input register
//   keeps one more transaction, after which evt_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer_core import i2cmts_pkg::*; #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  evt_valid,
	output logic                       evt_ready,
	input  wire i2cmts_in_t            evt,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output i2cmts_out_t                res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	i2cmts_cfg_t cfg;
	i2cmts_in_t  evt_s1;
	logic        evt_vld_s1;
	i2cmts_out_t res_s2;
	logic        res_vld_s2;
	i2cmts_out_t res_c;
	logic        adv;
	logic        take;

	// Advance the decision stage when the result slot is free or draining
	assign adv       = evt_vld_s1 && (!res_vld_s2 || res_ready);
	assign evt_ready = !evt_vld_s1 || adv;
	assign take      = evt_valid && evt_ready;

	i2cmts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cmts_seq #(
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.evt     (evt_s1),
		.cfg     (cfg),
		.res     (res_c)
	);

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_s1 <= 1'b0;
		end else if (take) begin
			evt_vld_s1 <= 1'b1;
		end else if (adv) begin
			evt_vld_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (take) begin
			evt_s1 <= evt;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv) begin
			res_vld_s2 <= 1'b1;
		end else if (res_ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid = res_vld_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

[hw/rtl/i2cmts_checker.sv]
// ----------------------------------------------------------------------------
// I2C transfer sequencer port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_transfer_sequencer_core_defines.svh"

module i2cmts_checker import i2cmts_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire i2cmts_out_t res
);

	// Stalled result transaction holds
	`I2CMTS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

	// No data-register value without a write
	`I2CMTS_ASSERT_NOW(a_dr_quiet, clk, arst_n, res_valid && !res.dr_write, res.dr_value == 8'h00, "dr_value set without dr_write")

	// No received data without a store
	`I2CMTS_ASSERT_NOW(a_rx_quiet, clk, arst_n, res_valid && !res.rx_byte_stored, res.rx_data == 8'h00, "rx_data set without rx_byte_stored")

	// A consumed transmit byte goes to the data register
	`I2CMTS_ASSERT_NOW(a_tx_write, clk, arst_n, res_valid && res.tx_byte_taken, res.dr_write, "tx byte taken without data register write")

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_chk (.*);

`default_nettype wire

[tb/sv/tb_i2c_master_transfer_sequencer_core.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives begin-write, begin-read and status-event transactions into the
// sequencer and checks every result against a cycle-free model of the
// transfer state. Directed transfers come first, then three randomized
// phases with different idle patterns, address settings and long receiver
// stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_i2c_master_transfer_sequencer_core;
	import i2cmts_pkg::*;

	// Status flag masks in the order {sb, addr, btf, txe, rxne, af}
	localparam logic [5:0] F_NONE = 6'b000000;
	localparam logic [5:0] F_SB   = 6'b100000;
	localparam logic [5:0] F_ADDR = 6'b010000;
	localparam logic [5:0] F_BTF  = 6'b001000;
	localparam logic [5:0] F_TXE  = 6'b000100;
	localparam logic [5:0] F_RXNE = 6'b000010;
	localparam logic [5:0] F_AF   = 6'b000001;
	localparam logic [5:0] F_ALL  = 6'b111111;

	localparam logic [APB_ADDR_W-1:0] MEM_DEV_PADDR = {REG_MEM_DEV, 2'b00};
	localparam logic [APB_ADDR_W-1:0] RD_DEV_PADDR  = {REG_RD_DEV, 2'b00};

	localparam int IDLE_LIMIT   = 1000;
	localparam int STALL_CYCLES = 60;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS  = 410;

	// Transfer-state predictor and store of expected results
	class transfer_tracker;
		i2cmts_phase_t phase;
		logic [7:0]    slave_addr;
		logic [7:0]    sub_addr;
		logic [15:0]   byte_count;
		logic          ack;
		logic          buffer_en;
		logic          event_en;
		logic          error_en;
		logic [7:0]    mem_dev_addr;
		logic [7:0]    rd_dev_addr;
		i2cmts_out_t   pending_results[$];
		int            error_count;

		function new();
			phase        = PH_IDLE;
			slave_addr   = '0;
			sub_addr     = '0;
			byte_count   = '0;
			ack          = 1'b0;
			buffer_en    = 1'b0;
			event_en     = 1'b0;
			error_en     = 1'b0;
			mem_dev_addr = MEM_DEV_ADDR_RST;
			rd_dev_addr  = RD_DEV_ADDR_RST;
			error_count  = 0;
		endfunction

		// Saturate at zero
		function void count_down();
			if (byte_count != 0)
				byte_count = byte_count - 16'd1;
		endfunction

		// Advance the transfer state and queue the expected result
		function void note_event(i2cmts_in_t item);
			i2cmts_out_t r;
			logic        events_on;
			logic        errors_on;
			logic        address_phase;
			r = '0;
			case (item.cmd)
				CMD_WRITE, CMD_READ: begin
					if (item.cmd == CMD_WRITE) begin
						slave_addr = mem_dev_addr;
						if (item.register_address > 9'd255)
							slave_addr = slave_addr | ADDR_PAGE_BIT;
						phase = PH_WRITE;
					end else begin
						slave_addr = rd_dev_addr;
						phase = PH_RD_ADDR;
					end
					sub_addr = item.register_address[7:0];
					byte_count = item.transfer_length;
					event_en = 1'b1;
					r.gen_start = 1'b1;
				end
				CMD_EVENT: begin
					events_on = event_en;
					errors_on = error_en;
					address_phase = (phase == PH_WRITE) || (phase == PH_RD_ADDR);
					if (events_on) begin
						if (item.start_sent) begin
							r.dr_write = 1'b1;
							if (address_phase) begin
								r.dr_value = slave_addr;
								error_en = 1'b1;
							end else begin
								r.dr_value = slave_addr | ADDR_READ_BIT;
							end
						end
						if (item.address_sent) begin
							if (address_phase) begin
								r.dr_write = 1'b1;
								r.dr_value = sub_addr;
								if (phase == PH_WRITE)
									buffer_en = (byte_count != 0);
							end else begin
								ack = (byte_count > 16'd1);
								buffer_en = 1'b1;
							end
						end
						if (item.byte_finished) begin
							if (phase == PH_RD_ADDR) begin
								r.gen_start = 1'b1;
								phase = PH_RD_DATA;
							end else begin
								event_en = 1'b0;
								error_en = 1'b0;
								r.gen_stop = 1'b1;
							end
						end
						if (buffer_en) begin
							if (item.tx_empty) begin
								r.dr_write = 1'b1;
								r.dr_value = item.tx_byte;
								r.tx_byte_taken = 1'b1;
								count_down();
								if (byte_count == 0)
									buffer_en = 1'b0;
							end
							if (item.rx_not_empty) begin
								r.rx_byte_stored = 1'b1;
								r.rx_data = item.rx_byte;
								count_down();
								if (byte_count == 16'd1) begin
									ack = 1'b0;
									r.gen_stop = 1'b1;
								end else if (byte_count == 0) begin
									buffer_en = 1'b0;
									event_en = 1'b0;
									error_en = 1'b0;
								end
							end
						end
					end
					if (errors_on && item.ack_failure) begin
						event_en = 1'b0;
						error_en = 1'b0;
						buffer_en = 1'b0;
						r.gen_stop = 1'b1;
					end
				end
				default: begin
				end
			endcase
			r.ack_enable        = ack;
			r.buffer_irq_enable = buffer_en;
			r.event_irq_enable  = event_en;
			r.error_irq_enable  = error_en;
			r.bytes_left        = byte_count;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] expected, logic [15:0] actual);
			if (expected !== actual) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, expected,
					actual);
				error_count++;
			end
		endfunction

		// Compare one result with the oldest expectation
		function void check_result(i2cmts_out_t actual);
			i2cmts_out_t expected;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, actual);
				error_count++;
				return;
			end
			expected = pending_results.pop_front();
			compare_field("dr_write", 16'(expected.dr_write), 16'(actual.dr_write));
			compare_field("dr_value", 16'(expected.dr_value), 16'(actual.dr_value));
			compare_field("gen_start", 16'(expected.gen_start), 16'(actual.gen_start));
			compare_field("gen_stop", 16'(expected.gen_stop), 16'(actual.gen_stop));
			compare_field("ack_enable", 16'(expected.ack_enable), 16'(actual.ack_enable));
			compare_field("buffer_irq_enable", 16'(expected.buffer_irq_enable),
				16'(actual.buffer_irq_enable));
			compare_field("event_irq_enable", 16'(expected.event_irq_enable),
				16'(actual.event_irq_enable));
			compare_field("error_irq_enable", 16'(expected.error_irq_enable),
				16'(actual.error_irq_enable));
			compare_field("tx_byte_taken", 16'(expected.tx_byte_taken),
				16'(actual.tx_byte_taken));
			compare_field("rx_byte_stored", 16'(expected.rx_byte_stored),
				16'(actual.rx_byte_stored));
			compare_field("rx_data", 16'(expected.rx_data), 16'(actual.rx_data));
			compare_field("bytes_left", expected.bytes_left, actual.bytes_left);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  evt_valid = 1'b0;
	logic                  evt_ready;
	i2cmts_in_t            evt = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	i2cmts_out_t           res;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	transfer_tracker tracker;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit stall_request = 1'b0;

	i2c_master_transfer_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watch both channels; stop on a long stretch with no transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && evt_ready)
				tracker.note_event(evt);
			if (res_valid && res_ready)
				tracker.check_result(res);
			if ((evt_valid && evt_ready) || (res_valid && res_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Drive res_ready: random idles, plus long hold-offs on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				res_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic i2cmts_in_t make_item(i2cmts_cmd_t cmd, logic [8:0] reg_addr,
		logic [15:0] len, logic [5:0] flags, logic [7:0] tx, logic [7:0] rx);
		i2cmts_in_t item;
		item.cmd = cmd;
		item.register_address = reg_addr;
		item.transfer_length = len;
		{item.start_sent, item.address_sent, item.byte_finished, item.tx_empty,
			item.rx_not_empty, item.ack_failure} = flags;
		item.tx_byte = tx;
		item.rx_byte = rx;
		return item;
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_item(input i2cmts_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= item;
		do @(posedge clk); while (!evt_ready);
		items_sent++;
	endtask

	// Status event with random side fields; sometimes corrupt or drop it
	task automatic send_status(input logic [5:0] flags);
		logic [5:0] f;
		f = flags;
		if ($urandom_range(99) < 3)
			return;
		if ($urandom_range(99) < 8)
			f = 6'($urandom());
		send_item(make_item(CMD_EVENT, 9'($urandom_range(511)), 16'($urandom()), f,
			8'($urandom()), 8'($urandom())));
	endtask

	// Well-formed write and read transfers mixed with noise
	task automatic run_transfers(input int count);
		int          target;
		int          kind;
		int          i;
		logic [15:0] len;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(4));
			if (kind < 45) begin
				send_item(make_item(CMD_WRITE, 9'($urandom_range(511)), len, 6'($urandom()),
					8'($urandom()), 8'($urandom())));
				send_status(F_SB);
				send_status(F_ADDR);
				for (i = 0; i < len && i < 6; i++)
					send_status(F_TXE);
				send_status(F_BTF);
			end else if (kind < 90) begin
				send_item(make_item(CMD_READ, 9'($urandom_range(511)), len, 6'($urandom()),
					8'($urandom()), 8'($urandom())));
				send_status(F_SB);
				send_status(F_ADDR);
				send_status(F_BTF);
				send_status(F_SB);
				send_status(F_ADDR);
				for (i = 0; i < len && i < 6; i++)
					send_status(F_RXNE);
			end else begin
				send_item(make_item(i2cmts_cmd_t'($urandom_range(3)),
					9'($urandom_range(511)), 16'($urandom()), 6'($urandom()),
					8'($urandom()), 8'($urandom())));
			end
		end
		evt_valid <= 1'b0;
	endtask

	// Wait until every expected result has come back, then let the pipe settle
	task automatic drain();
		do @(posedge clk); while (tracker.pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reprogram both addresses while idle, then run a randomized phase
	task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] mem,
		input logic [7:0] rd);
		drain();
		write_reg(MEM_DEV_PADDR, mem);
		tracker.mem_dev_addr = mem;
		write_reg(RD_DEV_PADDR, rd);
		tracker.rd_dev_addr = rd;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stall_request = 1'b1;
		run_transfers(PHASE_ITEMS / 2);
		stall_request = 1'b1;
		run_transfers(PHASE_ITEMS / 2);
	endtask

	initial begin
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Events while disabled and an unknown command
		send_item(make_item(CMD_EVENT, 9'h1FF, 16'hFFFF, F_ALL, 8'hFF, 8'hFF));
		send_item(make_item(CMD_RESERVED, 9'h1FF, 16'hFFFF, F_ALL, 8'hFF, 8'hFF));
		// Upper-page write; last event has tx and rx together, rx saturates at zero
		send_item(make_item(CMD_WRITE, 9'h1FF, 16'd2, F_NONE, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_SB, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_ADDR, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_TXE, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_TXE | F_RXNE, 8'hFF, 8'h5A));
		// Restart a busy write with a read; flags on the begin are ignored
		send_item(make_item(CMD_WRITE, 9'h100, 16'd3, F_NONE, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_SB, 8'h00, 8'h00));
		send_item(make_item(CMD_READ, 9'h0AB, 16'd3, F_ALL, 8'hA5, 8'h3C));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_SB, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_ADDR, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_BTF, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_SB, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_ADDR, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_RXNE, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_RXNE, 8'h00, 8'hFF));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_RXNE, 8'h00, 8'h81));
		// Full-length write aborted by an ack failure
		send_item(make_item(CMD_WRITE, 9'h000, 16'hFFFF, F_NONE, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_SB, 8'h00, 8'h00));
		send_item(make_item(CMD_EVENT, 9'h000, 16'h0000, F_AF, 8'h00, 8'h00));
		evt_valid <= 1'b0;

		run_phase(23, 80, 8'hFF, 8'h00);
		run_phase(80, 23, 8'h00, 8'hFF);
		run_phase(0, 0, 8'($urandom()), 8'($urandom()));

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
